### hdl/ang_pkg.sv
`timescale 1ns / 1ps
// ang_pkg: shared constants for the audio noise gate
// used by the gate core, its serial multiplier and the port checker

package ang_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int HOLD_WIDTH_DEF   = 16;

  localparam int CFG_W     = 16;  // width of every configuration register
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W    = 16;  // fraction bits of coefficients and gain
  localparam int GAIN_W    = 17;  // Q1.16 gain, 0 .. unity

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'h10000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LEVEL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_LEVEL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_COEFF  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_COEFF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_SAMPLES  = 3'd4;

  // register reset values
  localparam logic [CFG_W-1:0] OPEN_LEVEL_RST    = 16'd1036;
  localparam logic [CFG_W-1:0] CLOSE_LEVEL_RST   = 16'd1036;
  localparam logic [CFG_W-1:0] ATTACK_COEFF_RST  = 16'd65209;
  localparam logic [CFG_W-1:0] RELEASE_COEFF_RST = 16'd65533;
  localparam logic [CFG_W-1:0] HOLD_SAMPLES_RST  = 16'd2400;

endpackage

### hdl/ang_serial_mul.sv
`timescale 1ns / 1ps
// ang_serial_mul: unsigned shift-add multiplier, one multiplier bit per cycle
// depends on ang_pkg for the default multiplier width

module ang_serial_mul #(
  parameter int AW = 17,
  parameter int BW = ang_pkg::GAIN_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic             done_o,
  output logic [AW+BW-1:0] prod_o
);

  localparam int CNW = $clog2(BW + 1);

  logic [AW-1:0]  a_q;
  logic [BW-1:0]  b_q;
  logic [AW-1:0]  hi_q;
  logic [BW-1:0]  lo_q;
  logic [CNW-1:0] cnt_q;
  logic           busy_q;
  logic           done_q;
  logic [AW:0]    sum;

  assign sum = {1'b0, hi_q} + (b_q[0] ? {1'b0, a_q} : {(AW+1){1'b0}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNW'(BW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNW'(1);
        if (cnt_q == CNW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // accumulator shifts right, product bits drop into the low half
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      b_q  <= b_i;
      hi_q <= '0;
      lo_q <= '0;
    end else if (busy_q) begin
      hi_q <= sum[AW:1];
      lo_q <= {sum[0], lo_q[BW-1:1]};
      b_q  <= b_q >> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

### hdl/audio_noise_gate_core.sv
`timescale 1ns / 1ps
// audio_noise_gate_core: noise gate with hysteresis and hold, envelope and gain glide
// depends on ang_pkg and ang_serial_mul
//
//   channel  direction  handshake              payload
//   in       to block   in_valid_i/in_stall_o  sample_in_i
//   out      from block out_valid_o/out_stall_i sample_out_o, gate_open_o, gate_changed_o
//   cfg      to block   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// three products (envelope step, gain step, output) run one after another on the one
// bit-serial multiplier; the next input word is taken only once the previous word has
// moved into the output register.
// rst_ni clears the gate state and loads the register defaults, no clearing pass.
// a finished word waits in the output register; the next input word is taken meanwhile.
// cfg_ready_o is always high.

module audio_noise_gate_core #(
  parameter int SAMPLE_WIDTH = ang_pkg::SAMPLE_WIDTH_DEF,
  parameter int HOLD_WIDTH   = ang_pkg::HOLD_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]      sample_out_o,
  output logic                                gate_open_o,
  output logic                                gate_changed_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ang_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ang_pkg::CFG_W-1:0]           cfg_data_i
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int HW  = HOLD_WIDTH;
  localparam int GW  = ang_pkg::GAIN_W;
  localparam int FW  = ang_pkg::FRAC_W;
  localparam int AW  = (SW > GW) ? SW : GW;
  localparam int PW  = AW + GW;
  localparam int CW  = (SW > ang_pkg::CFG_W) ? SW : ang_pkg::CFG_W;
  localparam int HXW = (HW > ang_pkg::CFG_W) ? HW : ang_pkg::CFG_W;
  localparam logic [HXW-1:0] HOLD_MAX = HXW'((64'd1 << HW) - 64'd1);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_ENV_GO    = 3'd1;
  localparam logic [2:0] S_ENV_WAIT  = 3'd2;
  localparam logic [2:0] S_GATE      = 3'd3;
  localparam logic [2:0] S_GAIN_GO   = 3'd4;
  localparam logic [2:0] S_GAIN_WAIT = 3'd5;
  localparam logic [2:0] S_OUT_WAIT  = 3'd6;
  localparam logic [2:0] S_DONE      = 3'd7;

  // configuration
  logic [ang_pkg::CFG_W-1:0] open_level_q, close_level_q;
  logic [ang_pkg::CFG_W-1:0] attack_coeff_q, release_coeff_q, hold_samples_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_level_q    <= ang_pkg::OPEN_LEVEL_RST;
      close_level_q   <= ang_pkg::CLOSE_LEVEL_RST;
      attack_coeff_q  <= ang_pkg::ATTACK_COEFF_RST;
      release_coeff_q <= ang_pkg::RELEASE_COEFF_RST;
      hold_samples_q  <= ang_pkg::HOLD_SAMPLES_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ang_pkg::CFG_OPEN_LEVEL:    open_level_q    <= cfg_data_i;
        ang_pkg::CFG_CLOSE_LEVEL:   close_level_q   <= cfg_data_i;
        ang_pkg::CFG_ATTACK_COEFF:  attack_coeff_q  <= cfg_data_i;
        ang_pkg::CFG_RELEASE_COEFF: release_coeff_q <= cfg_data_i;
        ang_pkg::CFG_HOLD_SAMPLES:  hold_samples_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control and gate state
  logic [2:0]    state_q, state_d;
  logic [SW-1:0] env_q, env_d;
  logic [GW-1:0] gain_q, gain_d;
  logic          open_q, open_d;
  logic [HW-1:0] hold_q, hold_d;
  logic          changed_q, changed_d;
  logic          out_valid_q, out_valid_d;

  // per-word working registers
  logic [SW-1:0] mag_q;
  logic          sign_q;
  logic          dir_q;
  logic [SW-1:0] res_q;
  logic [SW-1:0] out_sample_q;
  logic          out_open_q, out_changed_q;

  logic          in_acc, out_take, out_load;
  logic [SW-1:0] raw, mag_in;
  logic          env_ge, env_gt;
  logic          mul_start, mul_done;
  logic [AW-1:0] mul_a;
  logic [GW-1:0] mul_b;
  logic [PW-1:0] prod, prod_neg;
  logic [SW-1:0] env_step;
  logic [GW-1:0] gain_step;
  logic [SW-1:0] res_d;
  logic [CW-1:0] env_ext, open_ext, close_ext;
  logic [HXW-1:0] hold_ext;
  logic [HW-1:0] hold_load;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  assign raw    = $unsigned(sample_in_i);
  assign mag_in = raw[SW-1] ? (~raw + SW'(1)) : raw;

  assign env_ge = (mag_q >= env_q);
  assign env_gt = (mag_q > env_q);

  assign env_ext   = CW'(env_q);
  assign open_ext  = CW'(open_level_q);
  assign close_ext = CW'(close_level_q);
  assign hold_ext  = HXW'(hold_samples_q);
  assign hold_load = (hold_ext > HOLD_MAX) ? {HW{1'b1}} : hold_ext[HW-1:0];

  // operand select for the shared multiplier
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      S_ENV_GO: begin
        mul_start = 1'b1;
        mul_a     = AW'(env_ge ? (mag_q - env_q) : (env_q - mag_q));
        mul_b     = GW'(env_gt ? attack_coeff_q : release_coeff_q);
      end
      S_GAIN_GO: begin
        mul_start = 1'b1;
        mul_a     = AW'(open_q ? (ang_pkg::UNITY_GAIN - gain_q) : gain_q);
        mul_b     = GW'(open_q ? attack_coeff_q : release_coeff_q);
      end
      S_GAIN_WAIT: begin
        // output product starts as soon as the new gain is known
        mul_start = mul_done;
        mul_a     = AW'(mag_q);
        mul_b     = gain_d;
      end
      default: ;
    endcase
  end

  ang_serial_mul #(
    .AW(AW),
    .BW(GW)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (prod)
  );

  assign env_step  = prod[FW +: SW];
  assign gain_step = prod[FW +: GW];
  assign prod_neg  = ~prod + PW'(1);
  // negative products round toward minus infinity
  assign res_d     = sign_q ? prod_neg[FW +: SW] : prod[FW +: SW];

  always_comb begin
    state_d     = state_q;
    env_d       = env_q;
    gain_d      = gain_q;
    open_d      = open_q;
    hold_d      = hold_q;
    changed_d   = changed_q;
    out_valid_d = out_valid_q;
    if (out_take) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_ENV_GO;
        end
      end
      S_ENV_GO: begin
        state_d = S_ENV_WAIT;
      end
      S_ENV_WAIT: begin
        if (mul_done) begin
          env_d   = dir_q ? (mag_q - env_step) : (mag_q + env_step);
          state_d = S_GATE;
        end
      end
      S_GATE: begin
        if (!open_q) begin
          if (env_ext >= open_ext) begin
            open_d = 1'b1;
            hold_d = hold_load;
          end
        end else if (env_ext < close_ext) begin
          if (hold_q != '0) begin
            hold_d = hold_q - HW'(1);
          end else begin
            open_d = 1'b0;
          end
        end else begin
          hold_d = hold_load;
        end
        changed_d = (open_d != open_q);
        state_d   = S_GAIN_GO;
      end
      S_GAIN_GO: begin
        state_d = S_GAIN_WAIT;
      end
      S_GAIN_WAIT: begin
        if (mul_done) begin
          gain_d  = open_q ? (ang_pkg::UNITY_GAIN - gain_step) : gain_step;
          state_d = S_OUT_WAIT;
        end
      end
      S_OUT_WAIT: begin
        if (mul_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      env_q       <= '0;
      gain_q      <= '0;
      open_q      <= 1'b0;
      hold_q      <= '0;
      changed_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      env_q       <= env_d;
      gain_q      <= gain_d;
      open_q      <= open_d;
      hold_q      <= hold_d;
      changed_q   <= changed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mag_q  <= mag_in;
      sign_q <= raw[SW-1];
    end
    if (state_q == S_ENV_GO) begin
      dir_q <= env_ge;
    end
    if (state_q == S_OUT_WAIT && mul_done) begin
      res_q <= res_d;
    end
    if (out_load) begin
      out_sample_q  <= res_q;
      out_open_q    <= open_q;
      out_changed_q <= changed_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_out_o   = $signed(out_sample_q);
  assign gate_open_o    = out_open_q;
  assign gate_changed_o = out_changed_q;

endmodule

### hdl/ang_checker.sv
`timescale 1ns / 1ps
// ang_checker: port-level checks on the noise gate core, attached by bind
// depends on ang_pkg and audio_noise_gate_core

module ang_checker #(
  parameter int SAMPLE_WIDTH = ang_pkg::SAMPLE_WIDTH_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  input logic                           gate_open_o,
  input logic                           gate_changed_o
);

  logic       in_acc, out_acc;
  logic       last_open_q;
  logic [1:0] pend_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // gate state of the last word handed out, and words taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_open_q <= 1'b0;
      pend_q      <= '0;
    end else begin
      if (out_acc) begin
        last_open_q <= gate_open_o;
      end
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_out_o)
      && $stable(gate_open_o) && $stable(gate_changed_o))
    else $error("stalled output word changed");

  a_changed_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> gate_changed_o == (gate_open_o != last_open_q))
    else $error("gate_changed does not match the gate state sequence");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input taken while a word is in work");

  a_no_spurious_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("output word without a matching input word");

endmodule

bind audio_noise_gate_core ang_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_ang_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .sample_out_o  (sample_out_o),
  .gate_open_o   (gate_open_o),
  .gate_changed_o(gate_changed_o)
);

### tb/sv/audio_noise_gate_core_tb.sv
`timescale 1ns / 1ps
// audio_noise_gate_core_tb: self-checking bench for the noise gate core
// drives samples and register writes, predicts every gated word and compares it
// depends on ang_pkg and audio_noise_gate_core

module audio_noise_gate_core_tb;

  localparam int SW            = 16;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 100;
  localparam int MAX_PRINTS    = 40;
  localparam int RAND_PHASES   = 9;
  localparam int PHASE_ITEMS   = 200;

  typedef struct packed {
    logic signed [SW-1:0] smp;
    logic                 opened;
    logic                 toggled;
  } gate_word_t;

  logic                              clk_i;
  logic                              rst_ni      = 1'b0;
  logic                              in_valid_i  = 1'b0;
  logic                              in_stall_o;
  logic signed [SW-1:0]              sample_in_i = '0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic signed [SW-1:0]              sample_out_o;
  logic                              gate_open_o;
  logic                              gate_changed_o;
  logic                              cfg_valid_i = 1'b0;
  logic                              cfg_ready_o;
  logic [ang_pkg::CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [ang_pkg::CFG_W-1:0]         cfg_data_i  = '0;

  // register copies as the block should hold them
  logic [ang_pkg::CFG_W-1:0] thr_open  = ang_pkg::OPEN_LEVEL_RST;
  logic [ang_pkg::CFG_W-1:0] thr_close = ang_pkg::CLOSE_LEVEL_RST;
  logic [ang_pkg::CFG_W-1:0] k_attack  = ang_pkg::ATTACK_COEFF_RST;
  logic [ang_pkg::CFG_W-1:0] k_release = ang_pkg::RELEASE_COEFF_RST;
  logic [ang_pkg::CFG_W-1:0] hold_len  = ang_pkg::HOLD_SAMPLES_RST;

  // gate state as the block should hold it
  logic [15:0]                env_pk  = '0;
  logic [ang_pkg::GAIN_W-1:0] gain_pk = '0;
  logic                       open_pk = 1'b0;
  logic [15:0]                hold_pk = '0;

  logic signed [SW-1:0] sample_q[$];
  gate_word_t           gated_q[$];
  gate_word_t           want_w;

  logic   word_taken = 1'b0;
  logic   drv_busy   = 1'b0;
  logic   idle_on    = 1'b1;
  int     gap_left   = 0;
  int     stall_left = 0;
  int     n_sent     = 0;
  int     n_checked  = 0;
  int     n_cfg      = 0;
  int     n_toggles  = 0;
  int     n_errors   = 0;
  int     n_phases   = 0;
  longint cycle_count = 0;

  audio_noise_gate_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_in_i    (sample_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sample_out_o   (sample_out_o),
    .gate_open_o    (gate_open_o),
    .gate_changed_o (gate_changed_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // one-pole step toward a target; the leftover distance is truncated
  function automatic logic [16:0] smooth_toward(input logic [16:0] cur, input logic [16:0] tgt,
                                                input logic [15:0] k);
    logic [33:0] step;
    if (tgt >= cur) begin
      step = k * (tgt - cur);
      return tgt - step[32:16];
    end else begin
      step = k * (cur - tgt);
      return tgt + step[32:16];
    end
  endfunction

  task automatic predict_gated_word(input logic signed [SW-1:0] smp);
    logic [16:0]        mag;
    logic [16:0]        env_next;
    logic               was_open;
    logic signed [34:0] prod;
    gate_word_t         w;
    mag = smp[SW-1] ? 17'h10000 - {1'b0, smp} : {1'b0, smp};
    env_next = smooth_toward({1'b0, env_pk}, mag,
                             (mag > {1'b0, env_pk}) ? k_attack : k_release);
    env_pk = env_next[15:0];
    was_open = open_pk;
    // hold register is as wide as the counter, so a load never saturates
    if (!open_pk) begin
      if (env_pk >= thr_open) begin
        open_pk = 1'b1;
        hold_pk = hold_len;
      end
    end else if (env_pk < thr_close) begin
      if (hold_pk != 0) hold_pk = hold_pk - 1'b1;
      else open_pk = 1'b0;
    end else begin
      hold_pk = hold_len;
    end
    if (open_pk) gain_pk = smooth_toward(gain_pk, ang_pkg::UNITY_GAIN, k_attack);
    else gain_pk = smooth_toward(gain_pk, 17'd0, k_release);
    prod = smp * $signed({1'b0, gain_pk});
    // bits above the fraction give the floor of the product
    w.smp     = prod[SW+15:16];
    w.opened  = open_pk;
    w.toggled = was_open ^ open_pk;
    if (w.toggled) n_toggles++;
    gated_q.push_back(w);
  endtask

  task automatic report_mismatch(input string what);
    n_errors++;
    if (n_errors <= MAX_PRINTS) $display("mismatch at %0t ns: %s", $realtime, what);
  endtask

  // monitor: check gated words, predict accepted samples, mirror register writes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (gated_q.size() == 0) begin
          report_mismatch($sformatf("word with nothing pending, sample_out %0d",
                                    sample_out_o));
        end else begin
          want_w = gated_q.pop_front();
          if (sample_out_o !== want_w.smp)
            report_mismatch($sformatf("word %0d sample_out %0d, want %0d", n_checked,
                                      sample_out_o, $signed(want_w.smp)));
          if (gate_open_o !== want_w.opened)
            report_mismatch($sformatf("word %0d gate_open %b, want %b", n_checked,
                                      gate_open_o, want_w.opened));
          if (gate_changed_o !== want_w.toggled)
            report_mismatch($sformatf("word %0d gate_changed %b, want %b", n_checked,
                                      gate_changed_o, want_w.toggled));
          n_checked++;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        predict_gated_word(sample_in_i);
        word_taken = 1'b1;
        n_sent++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          ang_pkg::CFG_OPEN_LEVEL:    thr_open  = cfg_data_i;
          ang_pkg::CFG_CLOSE_LEVEL:   thr_close = cfg_data_i;
          ang_pkg::CFG_ATTACK_COEFF:  k_attack  = cfg_data_i;
          ang_pkg::CFG_RELEASE_COEFF: k_release = cfg_data_i;
          ang_pkg::CFG_HOLD_SAMPLES:  hold_len  = cfg_data_i;
          default: ;
        endcase
        n_cfg++;
      end
    end
  end

  // driver: sample channel and output stall, both changing on the falling edge
  always @(negedge clk_i) begin
    if (word_taken) begin
      word_taken = 1'b0;
      drv_busy   = 1'b0;
      if (idle_on && $urandom_range(0, 2) == 0) begin
        gap_left = $urandom_range(1, 4);
      end
    end
    if (!drv_busy) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (sample_q.size() > 0) begin
        sample_in_i <= sample_q.pop_front();
        drv_busy = 1'b1;
      end
    end
    in_valid_i <= drv_busy;
    if (stall_left > 0) stall_left--;
    else if (idle_on && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 4);
    out_stall_i <= (stall_left > 0);
  end

  task automatic write_reg(input logic [ang_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ang_pkg::CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all(input logic [ang_pkg::CFG_W-1:0] o,
                           input logic [ang_pkg::CFG_W-1:0] c,
                           input logic [ang_pkg::CFG_W-1:0] a,
                           input logic [ang_pkg::CFG_W-1:0] r,
                           input logic [ang_pkg::CFG_W-1:0] h);
    write_reg(ang_pkg::CFG_OPEN_LEVEL, o);
    write_reg(ang_pkg::CFG_CLOSE_LEVEL, c);
    write_reg(ang_pkg::CFG_ATTACK_COEFF, a);
    write_reg(ang_pkg::CFG_RELEASE_COEFF, r);
    write_reg(ang_pkg::CFG_HOLD_SAMPLES, h);
  endtask

  task automatic wait_idle();
    while (sample_q.size() != 0 || drv_busy || gated_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    n_phases++;
  endtask

  function automatic logic [ang_pkg::CFG_W-1:0] pick_level();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 16'd32768;
      2: return ang_pkg::CFG_W'($urandom_range(32769, 65535));
      default: return ang_pkg::CFG_W'($urandom_range(0, 12000));
    endcase
  endfunction

  function automatic logic [ang_pkg::CFG_W-1:0] pick_coeff();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: return ang_pkg::CFG_W'($urandom_range(60000, 65535));
      default: return ang_pkg::CFG_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [ang_pkg::CFG_W-1:0] pick_hold();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return ang_pkg::CFG_W'($urandom_range(0, 65535));
      default: return ang_pkg::CFG_W'($urandom_range(0, 30));
    endcase
  endfunction

  // loud, quiet and mid segments push the gate through open, hold and close
  function automatic logic signed [SW-1:0] pick_sample(input int mode);
    int unsigned          mag;
    logic signed [SW-1:0] v;
    case (mode)
      0, 1, 2, 3: mag = $urandom_range(4000, 32767);
      4, 5, 6:    mag = $urandom_range(0, 300);
      7:          mag = $urandom_range(300, 4000);
      8:          return SW'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sd0;
          3: return 16'sd1;
          default: return -16'sd1;
        endcase
      end
    endcase
    v = mag[SW-1:0];
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  task automatic queue_random_phase(input int n_items);
    int mode;
    int k;
    k = 0;
    while (k < n_items) begin
      mode = $urandom_range(0, 9);
      repeat ($urandom_range(4, 60)) begin
        if (k < n_items) begin
          sample_q.push_back(pick_sample(mode));
          k++;
        end
      end
    end
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d words pending", cycle_count, gated_q.size());
    $display("audio_noise_gate_core_tb: errors");
    $finish;
  end

  initial begin
    int p;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, slow envelope, extremes of the sample range
    sample_q.push_back(16'sh7fff);
    sample_q.push_back(16'sh8000);
    sample_q.push_back(16'sh8000);
    sample_q.push_back(-16'sd1);
    sample_q.push_back(16'sd1);
    sample_q.push_back(16'sd0);
    wait_idle();

    // levels beyond the envelope range: full-scale input never opens the gate
    write_all('1, '1, '0, '1, '0);
    sample_q.push_back(16'sh8000);
    sample_q.push_back(16'sh7fff);
    wait_idle();

    // zero coefficients jump at once; open, hold run-out, close, reopen, close
    write_all(16'd1000, 16'd500, '0, '0, 16'd2);
    sample_q.push_back(16'sh8000);
    sample_q.push_back(16'sh7fff);
    sample_q.push_back(-16'sd1);
    sample_q.push_back(16'sd3);
    sample_q.push_back(-16'sd2);
    sample_q.push_back(16'sd0);
    sample_q.push_back(16'sd1200);
    sample_q.push_back(16'sd0);
    sample_q.push_back(16'sd0);
    sample_q.push_back(16'sd0);
    wait_idle();

    // zero open level opens at once, half-step gain shows floor rounding,
    // longest hold, writes past the last register are dropped
    write_all('0, '1, 16'd32768, 16'd16384, '1);
    for (int i = ang_pkg::CFG_HOLD_SAMPLES + 1; i < 2 ** ang_pkg::CFG_IDX_W; i++)
      write_reg(ang_pkg::CFG_IDX_W'(i), ang_pkg::CFG_W'($urandom));
    sample_q.push_back(16'sd0);
    sample_q.push_back(-16'sd5);
    sample_q.push_back(16'sd12345);
    sample_q.push_back(16'sh8000);
    sample_q.push_back(-16'sd1);
    wait_idle();

    for (p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: write_all('0, '0, '0, '0, '0);
        1: write_all('1, '1, '1, '1, '1);
        2: write_all(ang_pkg::OPEN_LEVEL_RST, ang_pkg::CLOSE_LEVEL_RST,
                     ang_pkg::ATTACK_COEFF_RST, ang_pkg::RELEASE_COEFF_RST,
                     ang_pkg::HOLD_SAMPLES_RST);
        default: write_all(pick_level(), pick_level(), pick_coeff(), pick_coeff(),
                           pick_hold());
      endcase
      if (p == RAND_PHASES - 1) idle_on = 1'b0;
      queue_random_phase(PHASE_ITEMS);
      wait_idle();
    end

    $display("summary: %0d samples over %0d setting phases, %0d register writes",
             n_sent, n_phases, n_cfg);
    $display("summary: %0d gated words checked, %0d gate transitions, %0d mismatches",
             n_checked, n_toggles, n_errors);
    if (n_errors == 0) $display("audio_noise_gate_core_tb: clean");
    else $display("audio_noise_gate_core_tb: errors");
    $finish;
  end

endmodule

### filelist.f
hdl/ang_pkg.sv
hdl/ang_serial_mul.sv
hdl/audio_noise_gate_core.sv
hdl/ang_checker.sv
tb/sv/audio_noise_gate_core_tb.sv
